FILE: rtl/pil_pkg.sv
`timescale 1ns / 1ps

package pil_pkg;

    localparam int KIND_BITS   = 2;
    localparam int POS_BITS    = 5;
    localparam int WORD_IN     = 32;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 5;
    localparam int S_DATA_BITS = 40;
    localparam int M_DATA_BITS = 40;

    localparam logic [KIND_BITS-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_ERASE  = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_READ   = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_LEFT,
        CELL_RIGHT
    } t_cell_op;

endpackage

FILE: rtl/pil_cell.sv
`timescale 1ns / 1ps

module pil_cell #(
    parameter int WORD_BITS = 32
) (
    input  logic                   i_clk,
    input  pil_pkg::t_cell_op      i_op,
    input  logic [WORD_BITS-1:0]   i_word,
    input  logic [WORD_BITS-1:0]   i_left,
    input  logic [WORD_BITS-1:0]   i_right,
    output logic [WORD_BITS-1:0]   o_value
);

    logic [WORD_BITS-1:0] r_value;
    logic [WORD_BITS-1:0] n_value;

    always_comb begin
        case (i_op)
            pil_pkg::CELL_LOAD:  n_value = i_word;
            pil_pkg::CELL_LEFT:  n_value = i_left;
            pil_pkg::CELL_RIGHT: n_value = i_right;
            default:             n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

FILE: rtl/positional_list_insert_erase.sv
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed words held in a row of cells.
// Input channel s_axis: tuser carries the operation kind (append, insert,
// erase, read); tdata carries the position and the word. Every transfer
// yields exactly one result on m_axis: tuser carries the status (done,
// position out of range, list full), tdata the word read and the count.
// An operation completes in the cycle it is accepted: each cell it touches
// loads the new word, takes its left neighbor (insert) or its right neighbor
// (erase) at that clock edge, so one transfer per cycle is sustained while
// m_axis_tready stays high. The result is registered at that same edge.
// When the receiver stalls, the result waits in the output register and
// s_axis_tready falls until it is taken; a new transfer is accepted in the
// same cycle the held result leaves.
// Reset clears the count and the output valid; the stored words are not
// cleared, since no position at or beyond the count can be read.
module positional_list_insert_erase #(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // position [4:0], word [36:5], zero [39:37]
    input  logic [1:0]  s_axis_tuser,  // kind [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // read_word [31:0], count [36:32], zero [39:37]
    output logic [1:0]  m_axis_tuser   // status [1:0]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW    = (CNT_W > pil_pkg::POS_BITS) ? CNT_W : pil_pkg::POS_BITS;

    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic                         r_m_valid;
    logic [pil_pkg::STATUS_BITS-1:0] r_status;
    logic [pil_pkg::STATUS_BITS-1:0] n_status;
    logic [WORD_BITS-1:0]         r_rd_word;
    logic [WORD_BITS-1:0]         n_rd_word;
    logic [CNT_W-1:0]             r_cnt_out;

    logic                         accept;
    logic [pil_pkg::KIND_BITS-1:0] kind;
    logic [PW-1:0]                pos_ext;
    logic [PW-1:0]                cnt_ext;
    logic [pil_pkg::WORD_IN-1:0]  word_in;
    logic [WORD_BITS-1:0]         word_st;
    logic                         full;
    logic                         ok;

    logic [WORD_BITS-1:0]         cell_val [CAPACITY];
    pil_pkg::t_cell_op            cell_op  [CAPACITY];

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign kind          = s_axis_tuser;
    assign pos_ext       = PW'(s_axis_tdata[pil_pkg::POS_BITS-1:0]);
    assign cnt_ext       = PW'(r_count);
    assign word_in       = s_axis_tdata[pil_pkg::POS_BITS +: pil_pkg::WORD_IN];
    assign full          = (r_count == CNT_W'(CAPACITY));

    generate
        if (WORD_BITS <= pil_pkg::WORD_IN) begin : g_wnarrow
            assign word_st = word_in[WORD_BITS-1:0];
        end else begin : g_wwide
            assign word_st = {{(WORD_BITS - pil_pkg::WORD_IN){word_in[pil_pkg::WORD_IN-1]}},
                              word_in};
        end
    endgenerate

    always_comb begin
        n_rd_word = '0;
        case (kind)
            pil_pkg::KIND_APPEND: n_status = full ? pil_pkg::ST_FULL : pil_pkg::ST_DONE;
            pil_pkg::KIND_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    n_status = pil_pkg::ST_RANGE;
                end else if (full) begin
                    n_status = pil_pkg::ST_FULL;
                end else begin
                    n_status = pil_pkg::ST_DONE;
                end
            end
            pil_pkg::KIND_ERASE: begin
                n_status = (pos_ext >= cnt_ext) ? pil_pkg::ST_RANGE : pil_pkg::ST_DONE;
            end
            default: begin
                if (pos_ext >= cnt_ext) begin
                    n_status = pil_pkg::ST_RANGE;
                end else begin
                    n_status  = pil_pkg::ST_DONE;
                    n_rd_word = cell_val[pos_ext[IDX_W-1:0]];
                end
            end
        endcase
        ok = (n_status == pil_pkg::ST_DONE);
        n_count = r_count;
        if (ok && (kind == pil_pkg::KIND_APPEND || kind == pil_pkg::KIND_INSERT)) begin
            n_count = r_count + 1'b1;
        end else if (ok && kind == pil_pkg::KIND_ERASE) begin
            n_count = r_count - 1'b1;
        end
    end

    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            logic [WORD_BITS-1:0] left_v;
            logic [WORD_BITS-1:0] right_v;

            if (i == 0) begin : g_first
                assign left_v = '0;
            end else begin : g_mid_l
                assign left_v = cell_val[i-1];
            end
            if (i == CAPACITY - 1) begin : g_last
                assign right_v = '0;
            end else begin : g_mid_r
                assign right_v = cell_val[i+1];
            end

            always_comb begin
                cell_op[i] = pil_pkg::CELL_HOLD;
                if (accept && ok) begin
                    case (kind)
                        pil_pkg::KIND_APPEND: begin
                            if (cnt_ext == PW'(i)) cell_op[i] = pil_pkg::CELL_LOAD;
                        end
                        pil_pkg::KIND_INSERT: begin
                            if (pos_ext == PW'(i)) begin
                                cell_op[i] = pil_pkg::CELL_LOAD;
                            end else if (pos_ext < PW'(i)) begin
                                cell_op[i] = pil_pkg::CELL_LEFT;
                            end
                        end
                        pil_pkg::KIND_ERASE: begin
                            if (pos_ext <= PW'(i) && i != CAPACITY - 1) begin
                                cell_op[i] = pil_pkg::CELL_RIGHT;
                            end
                        end
                        default: cell_op[i] = pil_pkg::CELL_HOLD;
                    endcase
                end
            end

            pil_cell #(
                .WORD_BITS(WORD_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_op    (cell_op[i]),
                .i_word  (word_st),
                .i_left  (left_v),
                .i_right (right_v),
                .o_value (cell_val[i])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_rd_word <= n_rd_word;
            r_cnt_out <= n_count;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata[36:32] = pil_pkg::COUNT_BITS'(r_cnt_out);
    assign m_axis_tdata[39:37] = '0;

    generate
        if (WORD_BITS >= pil_pkg::WORD_IN) begin : g_rwide
            assign m_axis_tdata[31:0] = r_rd_word[pil_pkg::WORD_IN-1:0];
        end else begin : g_rnarrow
            assign m_axis_tdata[31:0] = {{(pil_pkg::WORD_IN - WORD_BITS){1'b0}}, r_rd_word};
        end
    endgenerate

endmodule

FILE: rtl/pil_chk.sv
`timescale 1ns / 1ps

module pil_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("Stalled result changed.");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser == pil_pkg::ST_DONE
            || m_axis_tuser == pil_pkg::ST_RANGE || m_axis_tuser == pil_pkg::ST_FULL)
        else $error("Undefined status code.");

    a_word_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[31:0] != 32'd0 |-> m_axis_tuser == pil_pkg::ST_DONE)
        else $error("Word returned on a failed operation.");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("Input stalled with no result pending.");

endmodule

bind positional_list_insert_erase pil_chk u_pil_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/positional_list_insert_erase_tb.sv
`timescale 1ns / 1ps

module positional_list_insert_erase_tb;

    localparam int LIST_DEPTH = 16;

    typedef struct {
        logic [pil_pkg::STATUS_BITS-1:0] status;
        logic [31:0]                     read_word;
        logic [pil_pkg::COUNT_BITS-1:0]  count;
    } t_list_result;

    class t_list_mirror;
        logic [31:0]  cells [LIST_DEPTH];
        int           held;
        t_list_result due_results [$];
        int           mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        function void apply_op(logic [pil_pkg::KIND_BITS-1:0] kind,
                               logic [pil_pkg::POS_BITS-1:0] pos, logic [31:0] word);
            t_list_result r;
            int i;
            r.status = pil_pkg::ST_DONE;
            r.read_word = '0;
            case (kind)
                pil_pkg::KIND_APPEND: begin
                    if (held >= LIST_DEPTH) begin
                        r.status = pil_pkg::ST_FULL;
                    end else begin
                        cells[held] = word;
                        held++;
                    end
                end
                pil_pkg::KIND_INSERT: begin
                    if (int'(pos) > held) begin
                        r.status = pil_pkg::ST_RANGE;
                    end else if (held >= LIST_DEPTH) begin
                        r.status = pil_pkg::ST_FULL;
                    end else begin
                        for (i = held; i > int'(pos); i--) cells[i] = cells[i-1];
                        cells[pos] = word;
                        held++;
                    end
                end
                pil_pkg::KIND_ERASE: begin
                    if (int'(pos) >= held) begin
                        r.status = pil_pkg::ST_RANGE;
                    end else begin
                        for (i = int'(pos); i + 1 < held; i++) cells[i] = cells[i+1];
                        held--;
                    end
                end
                default: begin
                    if (int'(pos) >= held) begin
                        r.status = pil_pkg::ST_RANGE;
                    end else begin
                        r.read_word = cells[pos];
                    end
                end
            endcase
            r.count = held[pil_pkg::COUNT_BITS-1:0];
            due_results.insert(due_results.size(), r);
        endfunction

        function void flag(string field, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $realtime, field,
                         want, got);
        endfunction

        function void compare_result(logic [pil_pkg::STATUS_BITS-1:0] status,
                                     logic [31:0] read_word,
                                     logic [pil_pkg::COUNT_BITS-1:0] count);
            t_list_result e;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected transfer, status %0d word 0x%08h count %0d",
                             $realtime, status, read_word, count);
                return;
            end
            e = due_results.pop_front();
            if (status !== e.status) flag("status", 32'(e.status), 32'(status));
            if (read_word !== e.read_word) flag("read_word", e.read_word, read_word);
            if (count !== e.count) flag("count", 32'(e.count), 32'(count));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // position [4:0], word [36:5], zero [39:37]
    logic [1:0]  s_axis_tuser = '0;   // kind [1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // read_word [31:0], count [36:32], zero [39:37]
    logic [1:0]  m_axis_tuser;        // status [1:0]

    t_list_mirror mirror = new();
    int           idle_pct = 0;
    int           stall_pct = 0;

    positional_list_insert_erase uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("positional_list_insert_erase verification failed");
        $finish;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            mirror.compare_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[36:32]);
    end

    // Entered and left at a falling edge.
    task automatic send_op(logic [pil_pkg::KIND_BITS-1:0] kind,
                           logic [pil_pkg::POS_BITS-1:0] pos, logic [31:0] word);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {3'b000, word, pos};
        do @(posedge i_clk); while (!s_axis_tready);
        mirror.apply_op(kind, pos, word);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (mirror.due_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) return 32'h8000_0000;
        if (roll < 16) return 32'h7FFF_FFFF;
        if (roll < 20) return 32'h0000_0000;
        if (roll < 24) return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    // The trend steers the fill level: 0 grows the list, 1 shrinks it, 2 mixes.
    task automatic send_random_op(int trend);
        int roll;
        int n;
        logic [pil_pkg::KIND_BITS-1:0] kind;
        logic [pil_pkg::POS_BITS-1:0]  pos;
        n = mirror.held;
        roll = $urandom_range(99);
        case (trend)
            0: kind = roll < 35 ? pil_pkg::KIND_APPEND : roll < 65 ? pil_pkg::KIND_INSERT :
                      roll < 80 ? pil_pkg::KIND_ERASE : pil_pkg::KIND_READ;
            1: kind = roll < 10 ? pil_pkg::KIND_APPEND : roll < 25 ? pil_pkg::KIND_INSERT :
                      roll < 65 ? pil_pkg::KIND_ERASE : pil_pkg::KIND_READ;
            default: kind = roll < 20 ? pil_pkg::KIND_APPEND :
                            roll < 45 ? pil_pkg::KIND_INSERT :
                            roll < 65 ? pil_pkg::KIND_ERASE : pil_pkg::KIND_READ;
        endcase
        if ($urandom_range(99) < 12 || kind == pil_pkg::KIND_APPEND) begin
            pos = pil_pkg::POS_BITS'($urandom_range(LIST_DEPTH));
        end else if (kind == pil_pkg::KIND_INSERT) begin
            pos = pil_pkg::POS_BITS'($urandom_range(n));
        end else begin
            pos = (n == 0) ? '0 : pil_pkg::POS_BITS'($urandom_range(n - 1));
        end
        send_op(kind, pos, pick_word());
    endtask

    task automatic run_directed();
        int i;
        send_op(pil_pkg::KIND_READ, 5'd0, 32'h0);
        send_op(pil_pkg::KIND_ERASE, 5'd0, 32'h0);
        send_op(pil_pkg::KIND_INSERT, 5'd1, 32'h1234_5678);
        send_op(pil_pkg::KIND_INSERT, 5'd0, 32'hFFFF_FFFF);
        send_op(pil_pkg::KIND_APPEND, 5'd16, 32'h7FFF_FFFF);
        send_op(pil_pkg::KIND_APPEND, 5'd0, 32'h8000_0000);
        send_op(pil_pkg::KIND_INSERT, 5'd3, 32'h0000_0000);
        send_op(pil_pkg::KIND_INSERT, 5'd1, 32'hA5A5_5A5A);
        send_op(pil_pkg::KIND_READ, 5'd0, 32'hFFFF_FFFF);
        send_op(pil_pkg::KIND_READ, 5'd4, 32'h0);
        for (i = 0; i < 11; i++) send_op(pil_pkg::KIND_APPEND, 5'(i), $urandom());
        send_op(pil_pkg::KIND_APPEND, 5'd0, 32'h5555_5555);
        send_op(pil_pkg::KIND_INSERT, 5'd16, 32'h1111_1111);
        send_op(pil_pkg::KIND_INSERT, 5'd3, 32'h2222_2222);
        send_op(pil_pkg::KIND_READ, 5'd15, 32'h0);
        send_op(pil_pkg::KIND_READ, 5'd16, 32'h0);
        send_op(pil_pkg::KIND_ERASE, 5'd15, 32'h0);
        send_op(pil_pkg::KIND_ERASE, 5'd0, 32'h0);
        send_op(pil_pkg::KIND_ERASE, 5'd14, 32'h0);
        send_op(pil_pkg::KIND_INSERT, 5'd15, 32'h3333_3333);
    endtask

    initial begin
        int phase;
        int k;
        int trend_base;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            if (phase == 0) run_directed();
            trend_base = $urandom_range(2);
            for (k = 0; k < 170; k++) send_random_op((trend_base + k / 40) % 3);
            drain_results();
        end
        repeat (5) @(posedge i_clk);
        if (mirror.mismatches == 0 && mirror.due_results.size() == 0) begin
            $display("positional_list_insert_erase verification clean");
        end else begin
            $display("positional_list_insert_erase verification failed");
        end
        $finish;
    end

endmodule
